// ===== design/all_keywords_line_matcher_core_assert.svh =====
// Assertion macros for the line matcher core.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ALL_KEYWORDS_LINE_MATCHER_CORE_ASSERT_SVH
`define ALL_KEYWORDS_LINE_MATCHER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ALMK_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ALMK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ALMK_ASSERT_IMP(label, ante, cons)
`define ALMK_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/almk_pkg.sv =====
// Shared types, constants and register codes for the line matcher core.
// No dependencies.
package almk_pkg;

	localparam int MAX_WORD_LEN_DEF = 8;
	localparam int NUM_WORDS_DEF = 3;
	localparam int NUM_WORDS_MAX = 3;
	localparam int FIFO_DEPTH = 2;

	localparam logic [2:0] REG_ACTIVE_WORDS = 3'd0;
	localparam logic [2:0] REG_WORD0_CHARS = 3'd1;
	localparam logic [2:0] REG_WORD0_LEN = 3'd2;
	localparam logic [2:0] REG_WORD1_CHARS = 3'd3;
	localparam logic [2:0] REG_WORD1_LEN = 3'd4;
	localparam logic [2:0] REG_WORD2_CHARS = 3'd5;
	localparam logic [2:0] REG_WORD2_LEN = 3'd6;

	typedef struct packed {
		logic [7:0] line_byte;
		logic end_of_line;
		logic [7:0] line_tag;
	} in_word_t;

	typedef struct packed {
		logic all_found;
		logic [7:0] result_tag;
	} out_word_t;

	typedef struct packed {
		logic [1:0] active_words;
		logic [NUM_WORDS_MAX-1:0][63:0] word_chars;
		logic [NUM_WORDS_MAX-1:0][3:0] word_len;
	} cfg_t;

	typedef struct packed {
		logic [NUM_WORDS_MAX-1:0] match;
		logic eol;
		logic [7:0] tag;
	} q_entry_t;

endpackage

// ===== design/almk_front.sv =====
// Front end: takes line bytes, keeps the recent-byte window and flags which
// words end at each byte. Depends on almk_pkg.
module almk_front #(
	parameter int MAX_WORD_LEN = almk_pkg::MAX_WORD_LEN_DEF,
	parameter int NUM_WORDS = almk_pkg::NUM_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input almk_pkg::in_word_t in_word,
	input almk_pkg::cfg_t cfg,
	output almk_pkg::q_entry_t entry
);

	localparam int IW = $clog2(MAX_WORD_LEN);
	localparam int SW = $clog2(MAX_WORD_LEN + 1);

	logic [MAX_WORD_LEN-2:0][7:0] recent_q;
	logic [SW-1:0] seen_q;
	logic [MAX_WORD_LEN-1:0][7:0] win;

	always_comb begin
		win[0] = in_word.line_byte;
		for (int d = 1; d < MAX_WORD_LEN; d++) begin
			win[d] = recent_q[d-1];
		end
	end

	always_comb begin
		logic [3:0] len;
		logic [3:0] pos;
		logic ok;
		entry.eol = in_word.end_of_line;
		entry.tag = in_word.line_tag;
		entry.match = '0;
		for (int w = 0; w < almk_pkg::NUM_WORDS_MAX; w++) begin
			len = cfg.word_len[w];
			ok = 1'b1;
			for (int p = 0; p < MAX_WORD_LEN; p++) begin
				pos = len - 4'(p) - 4'd1;
				if (4'(p) < len && win[pos[IW-1:0]] != cfg.word_chars[w][8*p +: 8]) begin
					ok = 1'b0;
				end
			end
			if (w < NUM_WORDS) begin
				if (len == 4'd0) begin
					entry.match[w] = 1'b1;
				end else if (len > 4'(MAX_WORD_LEN)) begin
					entry.match[w] = 1'b0;
				end else if ((len - 4'd1) > 4'(seen_q)) begin
					entry.match[w] = 1'b0;
				end else begin
					entry.match[w] = ok;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			seen_q <= '0;
		end else if (accept) begin
			if (in_word.end_of_line) begin
				recent_q <= '0;
				seen_q <= '0;
			end else begin
				for (int k = MAX_WORD_LEN - 2; k > 0; k--) begin
					recent_q[k] <= recent_q[k-1];
				end
				recent_q[0] <= in_word.line_byte;
				if (seen_q < SW'(MAX_WORD_LEN)) begin
					seen_q <= seen_q + SW'(1);
				end
			end
		end
	end

endmodule

// ===== design/almk_fifo.sv =====
// Short queue of classified bytes between the front and back ends.
// Depends on almk_pkg.
module almk_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input almk_pkg::q_entry_t din,
	input logic pop,
	output almk_pkg::q_entry_t dout,
	output logic full,
	output logic empty
);

	localparam int D = almk_pkg::FIFO_DEPTH;
	localparam int PW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	almk_pkg::q_entry_t mem_q [D];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(D));
	assign empty = (count_q == '0);
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(D - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(D - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== design/almk_back.sv =====
// Back end: gathers found flags per line and issues one result word per line
// through an output register. Depends on almk_pkg and the assertion header.
`include "all_keywords_line_matcher_core_assert.svh"

module almk_back #(
	parameter int NUM_WORDS = almk_pkg::NUM_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input almk_pkg::q_entry_t head,
	input logic empty,
	input logic [1:0] active_words,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output almk_pkg::out_word_t out_word
);

	logic [NUM_WORDS-1:0] found_q;
	logic [NUM_WORDS-1:0] hit;
	logic [NUM_WORDS-1:0] mask;
	logic [1:0] act;
	logic out_valid_q;
	almk_pkg::out_word_t out_word_q;

	assign act = (active_words > 2'(NUM_WORDS)) ? 2'(NUM_WORDS) : active_words;
	assign hit = found_q | head.match[NUM_WORDS-1:0];
	assign pop = !empty && (!head.eol || !out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	always_comb begin
		for (int w = 0; w < NUM_WORDS; w++) begin
			mask[w] = (2'(w) < act);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				found_q <= head.eol ? '0 : hit;
			end
			if (pop && head.eol) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.eol) begin
			out_word_q.all_found <= &(hit | ~mask);
			out_word_q.result_tag <= head.tag;
		end
	end

	`ALMK_ASSERT_IMP(a_eol_needs_slot, pop && head.eol, !(out_valid_q && out_stall))
	`ALMK_ASSERT_NEXT(a_flags_clear, pop && head.eol, found_q == '0)
	`ALMK_ASSERT_NEXT(a_no_words_match, pop && head.eol && act == 2'd0, out_word_q.all_found)

endmodule

// ===== design/all_keywords_line_matcher_core.sv =====
// Line matcher core: reports whether a text line holds every query word.
// Input channel: one byte word per cycle (in_valid/in_stall), end_of_line on
// the last byte, line_tag echoed back. Output channel (out_valid/out_stall):
// one result word per line, all_found plus result_tag.
// Config channel (cfg_valid/cfg_ready, always ready): register index and
// data; write only while the block is idle.
// Throughput is one byte per cycle while in_stall is low: the window compare
// runs in the front end in the accept cycle, and a two-entry queue feeds the
// back end. A line's result passes from the last byte through the queue and
// then the output register before out_valid rises.
// A stalled result holds in the output register; bytes that end no line
// keep flowing until the queue fills, then in_stall rises.
// Reset clears the registers, the byte window, the queue and found flags.
// Depends on almk_pkg, almk_front, almk_fifo and almk_back.
module all_keywords_line_matcher_core #(
	parameter int MAX_WORD_LEN = almk_pkg::MAX_WORD_LEN_DEF,
	parameter int NUM_WORDS = almk_pkg::NUM_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input almk_pkg::in_word_t in_word,
	output logic out_valid,
	input logic out_stall,
	output almk_pkg::out_word_t out_word,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data
);

	almk_pkg::cfg_t cfg_q;
	almk_pkg::q_entry_t entry;
	almk_pkg::q_entry_t head;
	logic full;
	logic empty;
	logic pop;
	logic accept;

	assign cfg_ready = 1'b1;
	assign in_stall = full;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				almk_pkg::REG_ACTIVE_WORDS: cfg_q.active_words <= cfg_data[1:0];
				almk_pkg::REG_WORD0_CHARS: cfg_q.word_chars[0] <= cfg_data;
				almk_pkg::REG_WORD0_LEN: cfg_q.word_len[0] <= cfg_data[3:0];
				almk_pkg::REG_WORD1_CHARS: cfg_q.word_chars[1] <= cfg_data;
				almk_pkg::REG_WORD1_LEN: cfg_q.word_len[1] <= cfg_data[3:0];
				almk_pkg::REG_WORD2_CHARS: cfg_q.word_chars[2] <= cfg_data;
				almk_pkg::REG_WORD2_LEN: cfg_q.word_len[2] <= cfg_data[3:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	almk_front #(
		.MAX_WORD_LEN(MAX_WORD_LEN),
		.NUM_WORDS(NUM_WORDS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.in_word(in_word),
		.cfg(cfg_q),
		.entry(entry)
	);

	almk_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.din(entry),
		.pop(pop),
		.dout(head),
		.full(full),
		.empty(empty)
	);

	almk_back #(
		.NUM_WORDS(NUM_WORDS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.active_words(cfg_q.active_words),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

endmodule

// ===== dv/tb_all_keywords_line_matcher_core.sv =====
// Testbench for all_keywords_line_matcher_core: streams text lines byte by byte and checks
// each line result against a built-in model of the window compare and found flags.
// Depends on almk_pkg and the core; self-contained otherwise.
module tb_all_keywords_line_matcher_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam logic [2:0] CHARS_REG [almk_pkg::NUM_WORDS_DEF] =
		'{almk_pkg::REG_WORD0_CHARS, almk_pkg::REG_WORD1_CHARS, almk_pkg::REG_WORD2_CHARS};
	localparam logic [2:0] LEN_REG [almk_pkg::NUM_WORDS_DEF] =
		'{almk_pkg::REG_WORD0_LEN, almk_pkg::REG_WORD1_LEN, almk_pkg::REG_WORD2_LEN};
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int NUM_PHASES = 12;
	localparam int PHASE_BYTES = 84;

	typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;

	typedef struct {
		row_kind_e kind;
		logic [2:0] idx;
		logic [63:0] data;
		almk_pkg::in_word_t w;
		bit typed;
		bit want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	almk_pkg::in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	almk_pkg::out_word_t out_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	logic [7:0] win_bytes [almk_pkg::MAX_WORD_LEN_DEF-1] = '{default: '0};
	int win_fill = 0;
	bit word_hit [almk_pkg::NUM_WORDS_DEF] = '{default: 1'b0};
	logic [1:0] q_active = '0;
	logic [63:0] q_chars [almk_pkg::NUM_WORDS_DEF] = '{default: '0};
	logic [3:0] q_len [almk_pkg::NUM_WORDS_DEF] = '{default: '0};

	almk_pkg::out_word_t pending_results [$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int cycles = 0;
	int bytes_sent = 0;
	int lines_done = 0;
	int lines_hit = 0;
	int reg_writes = 0;
	int stall_cycles = 0;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;

	dir_row_t dir_tab [31] = '{
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'h00, 1'b1, 8'h00}), 1'b1, 1'b1},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'hFF, 1'b1, 8'hFF}), 1'b1, 1'b1},
		'{ROW_CFG, almk_pkg::REG_ACTIVE_WORDS, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0},
		'{ROW_CFG, almk_pkg::REG_WORD0_CHARS, 64'hFFFF_FFFF_FFFF_6261, '0, 1'b0, 1'b0},
		'{ROW_CFG, almk_pkg::REG_WORD0_LEN, 64'hFFFF_FFFF_FFFF_FFF2, '0, 1'b0, 1'b0},
		'{ROW_CFG, almk_pkg::REG_WORD1_CHARS, 64'h0123_4567_89AB_CDEF, '0, 1'b0, 1'b0},
		'{ROW_CFG, almk_pkg::REG_WORD1_LEN, 64'h0000_0000_0000_0010, '0, 1'b0, 1'b0},
		'{ROW_CFG, almk_pkg::REG_WORD2_CHARS, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0},
		'{ROW_CFG, almk_pkg::REG_WORD2_LEN, 64'h0000_0000_0000_0008, '0, 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'h61, 1'b0, 8'h01}), 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'h62, 1'b0, 8'h02}), 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'hFF, 1'b0, 8'h10}), 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'hFF, 1'b0, 8'h11}), 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'hFF, 1'b0, 8'h12}), 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'hFF, 1'b0, 8'h13}), 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'hFF, 1'b0, 8'h14}), 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'hFF, 1'b0, 8'h15}), 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'hFF, 1'b0, 8'h16}), 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'hFF, 1'b1, 8'h80}), 1'b1, 1'b1},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'h62, 1'b0, 8'h03}), 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'h61, 1'b1, 8'h04}), 1'b1, 1'b0},
		'{ROW_CFG, almk_pkg::REG_WORD2_LEN, 64'h0000_0000_0000_000F, '0, 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'h61, 1'b0, 8'h05}), 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'h62, 1'b1, 8'h06}), 1'b1, 1'b0},
		'{ROW_CFG, almk_pkg::REG_ACTIVE_WORDS, 64'h0000_0000_0000_0002, '0, 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'h61, 1'b0, 8'h07}), 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'h62, 1'b1, 8'h08}), 1'b1, 1'b1},
		'{ROW_CFG, REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'h00, 1'b0, 8'h09}), 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'h61, 1'b0, 8'h0A}), 1'b0, 1'b0},
		'{ROW_BYTE, '0, '0, almk_pkg::in_word_t'({8'h62, 1'b1, 8'hAA}), 1'b1, 1'b1}
	};

	all_keywords_line_matcher_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic bit word_ends_at(int wi, logic [7:0] cur);
		int n;
		int d;
		logic [7:0] b;
		n = q_len[wi];
		if (n == 0) return 1'b1;
		if (n > almk_pkg::MAX_WORD_LEN_DEF) return 1'b0;
		if (n - 1 > win_fill) return 1'b0;
		for (d = 0; d < n; d++) begin
			b = (d == 0) ? cur : win_bytes[d-1];
			if (b !== q_chars[wi][8*(n-1-d) +: 8]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit match_line_byte(almk_pkg::in_word_t w,
		output almk_pkg::out_word_t r);
		int i;
		r = '0;
		for (i = 0; i < almk_pkg::NUM_WORDS_DEF; i++) begin
			if (word_ends_at(i, w.line_byte)) word_hit[i] = 1'b1;
		end
		if (w.end_of_line) begin
			r.all_found = 1'b1;
			for (i = 0; i < almk_pkg::NUM_WORDS_DEF && i < q_active; i++) begin
				if (!word_hit[i]) r.all_found = 1'b0;
			end
			r.result_tag = w.line_tag;
			for (i = 0; i < almk_pkg::MAX_WORD_LEN_DEF - 1; i++) win_bytes[i] = '0;
			for (i = 0; i < almk_pkg::NUM_WORDS_DEF; i++) word_hit[i] = 1'b0;
			win_fill = 0;
			return 1'b1;
		end
		for (i = almk_pkg::MAX_WORD_LEN_DEF - 2; i > 0; i--) win_bytes[i] = win_bytes[i-1];
		win_bytes[0] = w.line_byte;
		if (win_fill < almk_pkg::MAX_WORD_LEN_DEF) win_fill++;
		return 1'b0;
	endfunction

	function automatic void store_reg(logic [2:0] idx, logic [63:0] data);
		case (idx)
			almk_pkg::REG_ACTIVE_WORDS: q_active = data[1:0];
			almk_pkg::REG_WORD0_CHARS: q_chars[0] = data;
			almk_pkg::REG_WORD0_LEN: q_len[0] = data[3:0];
			almk_pkg::REG_WORD1_CHARS: q_chars[1] = data;
			almk_pkg::REG_WORD1_LEN: q_len[1] = data[3:0];
			almk_pkg::REG_WORD2_CHARS: q_chars[2] = data;
			almk_pkg::REG_WORD2_LEN: q_len[2] = data[3:0];
			default: ;
		endcase
	endfunction

	function automatic void report_mismatch(string what, almk_pkg::out_word_t want_w,
		almk_pkg::out_word_t got_w);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch (%s): expected found=%0d tag=%02h, got found=%0d tag=%02h",
				what, want_w.all_found, want_w.result_tag, got_w.all_found,
				got_w.result_tag);
		end
	endfunction

	task automatic send_word(input almk_pkg::in_word_t w, input bit typed, input bit want);
		almk_pkg::out_word_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
		if (match_line_byte(w, r)) begin
			if (typed) r.all_found = want;
			pending_results.push_back(r);
			lines_done++;
			if (r.all_found) lines_hit++;
		end
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		store_reg(idx, data);
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_lines(input int n_items, input int max_len, input bit narrow);
		logic [7:0] ln [48];
		almk_pkg::in_word_t w;
		int n;
		int sent;
		int i;
		int p;
		int wi;
		int k;
		sent = 0;
		while (sent < n_items) begin
			n = $urandom_range(max_len, 1);
			if (max_len > 2 && $urandom_range(19) == 0) n = $urandom_range(48, 25);
			for (i = 0; i < n; i++) begin
				ln[i] = narrow ? 8'(8'h61 + $urandom_range(3)) : 8'($urandom_range(255));
			end
			for (wi = 0; wi < almk_pkg::NUM_WORDS_DEF; wi++) begin
				if (q_len[wi] != 0 && q_len[wi] <= almk_pkg::MAX_WORD_LEN_DEF &&
					q_len[wi] <= n && $urandom_range(9) < 7) begin
					p = $urandom_range(n - q_len[wi], 0);
					for (k = 0; k < q_len[wi]; k++) ln[p+k] = q_chars[wi][8*k +: 8];
					if ($urandom_range(9) == 0) begin
						k = $urandom_range(q_len[wi] - 1, 0);
						ln[p+k] = ln[p+k] ^ 8'(1 << $urandom_range(7));
					end
				end
			end
			for (i = 0; i < n; i++) begin
				w.line_byte = ln[i];
				w.end_of_line = (i == n - 1);
				w.line_tag = 8'($urandom_range(255));
				send_word(w, 1'b0, 1'b0);
				sent++;
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		almk_pkg::out_word_t want_w;
		if (in_valid && in_stall) stall_cycles++;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no line pending", '0, out_word);
			end else begin
				want_w = pending_results.pop_front();
				if (out_word.all_found !== want_w.all_found)
					report_mismatch("all_found", want_w, out_word);
				if (out_word.result_tag !== want_w.result_tag)
					report_mismatch("result_tag", want_w, out_word);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		dir_row_t row;
		bit cfg_open;
		int r;
		int ph;
		int wi;
		int b;
		int len;
		logic [63:0] d;
		logic [63:0] chars;
		cfg_open = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (r = 0; r < $size(dir_tab); r++) begin
			row = dir_tab[r];
			if (row.kind == ROW_CFG) begin
				if (!cfg_open) wait_idle();
				cfg_write(row.idx, row.data);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) begin
					cfg_valid <= 1'b0;
					cfg_open = 1'b0;
				end
				send_word(row.w, row.typed, row.want);
			end
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			send_idle_pct = (ph < 4) ? 15 : (ph < 8) ? 61 : 0;
			recv_idle_pct = (ph < 4) ? 61 : (ph < 8) ? 15 : 0;
			d = {$urandom, $urandom};
			if (ph == 0) d[1:0] = 2'd3;
			if (ph == 1) d[1:0] = 2'd0;
			cfg_write(almk_pkg::REG_ACTIVE_WORDS, d);
			for (wi = 0; wi < almk_pkg::NUM_WORDS_DEF; wi++) begin
				for (b = 0; b < 8; b++) begin
					chars[8*b +: 8] = (ph % 3 != 2) ? 8'(8'h61 + $urandom_range(3))
						: 8'($urandom_range(255));
				end
				if (ph == 2) chars = '0;
				if (ph == 5) chars = '1;
				cfg_write(CHARS_REG[wi], chars);
				len = $urandom_range(11);
				if (len > almk_pkg::MAX_WORD_LEN_DEF) len = $urandom_range(15, 9);
				if (ph == 0) len = almk_pkg::MAX_WORD_LEN_DEF;
				if (ph == 1) len = 0;
				d = {$urandom, $urandom};
				d[3:0] = 4'(len);
				cfg_write(LEN_REG[wi], d);
			end
			cfg_write(REG_UNUSED, {$urandom, $urandom});
			cfg_valid <= 1'b0;
			if (ph == 8) begin
				// Output held off while short lines keep coming, so the core backs up.
				@(posedge clk);
				hold_req = 1'b1;
				@(negedge clk);
				run_lines(40, 2, 1'b1);
			end
			run_lines(PHASE_BYTES, 24, ph % 3 != 2);
		end
		wait_idle();

		$display("Streamed %0d bytes in %0d lines (%0d matching) across %0d register writes.",
			bytes_sent, lines_done, lines_hit, reg_writes);
		$display("Core held off input for %0d cycles; %0d mismatches.",
			stall_cycles, mismatches);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
